// ===== rtl/rank_sort_by_key_macros.svh =====
// Assertion macros for the rank sort RTL.
`ifndef RANK_SORT_BY_KEY_MACROS_SVH
`define RANK_SORT_BY_KEY_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rks_pkg.sv =====
// Package with types and constants for the rank sort block.
package rks_pkg;

  localparam int MAX_RECORDS = 8;
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 32;

  typedef struct packed {
    logic signed [KEY_W-1:0] sort_key;
    logic        [PAY_W-1:0] record_payload;
    logic                    final_record;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] out_key;
    logic        [PAY_W-1:0] out_payload;
    logic                    out_last;
  } out_item_t;

  // One stored record as it sits in a cell.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } rks_entry_t;

  // Chain-wide control: insert shifts right from the insertion point,
  // drain shifts every cell one place toward the head.
  typedef struct packed {
    logic insert;
    logic drain;
  } rks_ctl_t;

endpackage

// ===== rtl/rank_sort_by_key.sv =====
// Top level of the stable rank sorter: a chain of insertion cells.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    rks_pkg::in_item_t
//   out_     output     out_valid/out_ready  rks_pkg::out_item_t
//
// Load: one record per cycle. Every cell compares its key to the arriving
// key in parallel; the chain stays sorted by shifting right from the
// insertion point. A record that meets a full chain is dropped.
// After the final record the block drains one result per cycle from the
// head cell, then takes records again; in_ready is low while draining.
// Reset (synchronous, rst_n low) empties the chain and selects load mode.
// A stall on out_ready holds the head cell and the whole chain.
module rank_sort_by_key (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rks_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rks_pkg::out_item_t   out_data
);

  `include "rank_sort_by_key_macros.svh"

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                state_r, state_nxt;
  rks_pkg::rks_ctl_t   ctl;
  rks_pkg::rks_entry_t ent   [rks_pkg::MAX_RECORDS];
  logic                place [rks_pkg::MAX_RECORDS];
  logic [rks_pkg::MAX_RECORDS-1:0] valid_vec;
  logic [rks_pkg::MAX_RECORDS-1:0] valid_inc;
  logic                in_acc, out_acc, full;
  logic                last_acc;

  // Cells fill from the head, so the tail valid bit means full.
  assign full    = valid_vec[rks_pkg::MAX_RECORDS-1];
  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc  = in_valid && in_ready;
  assign out_valid = (state_r == ST_DRAIN) && ent[0].valid;
  assign out_acc = out_valid && out_ready;

  // Drop the record when the chain is full; a final flag still counts.
  assign ctl.insert = in_acc && !full;
  assign ctl.drain  = out_acc;

  // The head cell is the output register.
  assign out_data.out_key     = ent[0].key;
  assign out_data.out_payload = ent[0].payload;
  assign out_data.out_last    = !ent[1].valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_data.final_record) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && out_data.out_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Build the chain: each cell sees its left and right neighbors.
  for (genvar i = 0; i < rks_pkg::MAX_RECORDS; i++) begin : g_cell
    rks_pkg::rks_entry_t left_ent, right_ent;
    logic                left_place;

    if (i == 0) begin : g_head
      assign left_ent   = '0;
      assign left_place = 1'b0;
    end else begin : g_mid
      assign left_ent   = ent[i-1];
      assign left_place = place[i-1];
    end

    if (i == rks_pkg::MAX_RECORDS-1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = ent[i+1];
    end

    rks_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_key     (in_data.sort_key),
      .new_payload (in_data.record_payload),
      .left_ent    (left_ent),
      .left_place  (left_place),
      .right_ent   (right_ent),
      .ent         (ent[i]),
      .place       (place[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  // A run of ones from bit zero turns into a single carry out when incremented.
  assign valid_inc = valid_vec + {{(rks_pkg::MAX_RECORDS-1){1'b0}}, 1'b1};
  assign last_acc  = out_acc && out_data.out_last;

  // Valid cells always form a contiguous run from the head.
  `RKS_ASSERT_NOW(a_valid_prefix, clk, rst_n, 1'b1,
    (valid_inc & valid_vec) == '0, "rks: gap in valid cells")
  // Never take input while results are on offer.
  `RKS_ASSERT_NOW(a_no_overlap, clk, rst_n, in_ready, !out_valid,
    "rks: load and drain overlap")
  // After the last result the block is ready to load again, chain empty.
  `RKS_ASSERT_NEXT(a_last_empties, clk, rst_n, last_acc,
    in_ready && (valid_vec == '0), "rks: chain not empty after last")
  // A record that meets a full chain leaves the chain unchanged.
  `RKS_ASSERT_NEXT(a_full_drop, clk, rst_n, in_acc && full, $stable(valid_vec),
    "rks: full chain changed on drop")

endmodule

// ===== rtl/rks_cell.sv =====
// One cell of the sorted record chain.
module rks_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rks_pkg::rks_ctl_t         ctl,
  input  logic signed [rks_pkg::KEY_W-1:0] new_key,
  input  logic        [rks_pkg::PAY_W-1:0] new_payload,
  input  rks_pkg::rks_entry_t       left_ent,
  input  logic                      left_place,
  input  rks_pkg::rks_entry_t       right_ent,
  output rks_pkg::rks_entry_t       ent,
  output logic                      place
);

  logic                             valid_r, valid_nxt;
  logic signed [rks_pkg::KEY_W-1:0] key_r, key_nxt;
  logic        [rks_pkg::PAY_W-1:0] pay_r, pay_nxt;

  // Equal keys stay ahead of the new record, so ordering is stable.
  assign place = !valid_r || (key_r > new_key);

  assign ent = '{valid: valid_r, key: key_r, payload: pay_r};

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    if (ctl.drain) begin
      valid_nxt = right_ent.valid;
      key_nxt   = right_ent.key;
      pay_nxt   = right_ent.payload;
    end else if (ctl.insert && place) begin
      if (left_place) begin
        valid_nxt = left_ent.valid;
        key_nxt   = left_ent.key;
        pay_nxt   = left_ent.payload;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = new_key;
        pay_nxt   = new_payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

endmodule

// ===== tb/rank_sort_checker.sv =====
// Checker for the rank sorter: predicts stable sorted output per set and compares it.
module rank_sort_checker
  import rks_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        pending_count,
  output int        results_checked
);

  in_item_t  held_set[$];
  out_item_t sorted_due[$];

  initial begin
    mismatch_count  = 0;
    pending_count   = 0;
    results_checked = 0;
  end

  // Insert after every held key that is less than or equal, so ties keep arrival order.
  task automatic absorb_record(input in_item_t rec);
    int        pos;
    out_item_t res;
    if (held_set.size() < MAX_RECORDS) begin
      pos = 0;
      while (pos < held_set.size() &&
             $signed(held_set[pos].sort_key) <= $signed(rec.sort_key))
        pos++;
      held_set.insert(pos, rec);
    end
    if (rec.final_record) begin
      foreach (held_set[i]) begin
        res.out_key     = held_set[i].sort_key;
        res.out_payload = held_set[i].record_payload;
        res.out_last    = (i == held_set.size() - 1);
        sorted_due.push_back(res);
      end
      held_set.delete();
    end
  endtask

  task automatic report_fault(input string what, input out_item_t want, input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): expected key %0d payload %h last %b, got key %0d payload %h last %b",
               what, $signed(want.out_key), want.out_payload, want.out_last,
               $signed(got.out_key), got.out_payload, got.out_last);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held_set.delete();
      sorted_due.delete();
    end else begin
      if (in_valid && in_ready)
        absorb_record(in_data);
      if (out_valid && out_ready) begin
        results_checked++;
        if (sorted_due.size() == 0) begin
          want = '0;
          report_fault("no result pending", want, out_data);
        end else begin
          want = sorted_due.pop_front();
          if (want.out_key !== out_data.out_key ||
              want.out_payload !== out_data.out_payload ||
              want.out_last !== out_data.out_last)
            report_fault("field", want, out_data);
        end
      end
    end
    pending_count = sorted_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the rank sorter testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;

  typedef enum int {KEYS_WIDE, KEYS_CLUSTERED, KEYS_EXTREME} key_mix_e;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_e;

  // Stored records in the random phase; with drops and the directed sets
  // this comes to about 180 records sent.
  localparam int RANDOM_ITEMS = 150;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  rks_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rks_pkg::out_item_t out_data;

  int mismatch_count;
  int pending_count;
  int results_checked;

  int burst_left   = 0;
  int items_sent   = 0;
  int sets_sent    = 0;
  int drops_forced = 0;

  rx_mode_e rx_mode  = RX_OPEN;
  int       rx_cycle = 0;

  always #10 clk = ~clk;

  rank_sort_by_key u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rank_sort_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .results_checked (results_checked)
  );

  // Receiver: switch stall behavior among the receive modes so stalls land on every
  // drain position, including stretches where ready never drops.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 150 == 0)
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= ((rx_cycle % 16) >= 6);
    endcase
  end

  // Offer one record and hold it until the transaction completes. Between
  // bursts, drop valid for a random gap; inside a burst, valid stays high.
  task automatic offer_record(input logic [rks_pkg::KEY_W-1:0] key,
                              input logic [rks_pkg::PAY_W-1:0] pay,
                              input logic fin);
    rks_pkg::in_item_t rec;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      // Mostly short bursts, now and then a long stretch with no gaps.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
    end
    rec.sort_key       = key;
    rec.record_payload = pay;
    rec.final_record   = fin;
    in_data  <= rec;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
    if (fin)
      sets_sent++;
  endtask

  function automatic logic [rks_pkg::KEY_W-1:0] pick_key(input key_mix_e mix);
    case (mix)
      KEYS_WIDE:      return $urandom;
      // Narrow range around zero: plenty of ties.
      KEYS_CLUSTERED: return $urandom_range(0, 6) - 3;
      default: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  initial begin
    int       stored;
    int       set_len;
    key_mix_e mix;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-record set at the largest key.
    offer_record(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // Extremes of the key range, plus ties on zero and minus one.
    offer_record(32'h8000_0000, 32'h0000_0000, 1'b0);
    offer_record(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    offer_record(32'h0000_0000, 32'h0000_0002, 1'b0);
    offer_record(32'hFFFF_FFFF, 32'h0000_0003, 1'b0);
    offer_record(32'h0000_0001, 32'h0000_0004, 1'b0);
    offer_record(32'h0000_0000, 32'h0000_0005, 1'b0);
    offer_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // Full store: eight equal keys, then a final record that must be dropped
    // while the held set is still emitted in arrival order.
    for (int i = 0; i < rks_pkg::MAX_RECORDS; i++)
      offer_record(32'd5, i, 1'b0);
    offer_record(32'd5, 32'hDEAD_BEEF, 1'b1);
    drops_forced++;

    // Exactly full, descending keys: every arrival lands at the head.
    for (int i = 0; i < rks_pkg::MAX_RECORDS; i++)
      offer_record(32'd100 - 32'd30 * i, 32'hA5A5_0000 | i, i == rks_pkg::MAX_RECORDS - 1);

    // Random sets: mostly well-formed sets that fit, some that overflow.
    stored = 0;
    while (stored < RANDOM_ITEMS) begin
      set_len = ($urandom_range(0, 4) == 0) ?
                $urandom_range(rks_pkg::MAX_RECORDS + 1, rks_pkg::MAX_RECORDS + 3) :
                $urandom_range(1, rks_pkg::MAX_RECORDS);
      mix = key_mix_e'($urandom_range(0, 2));
      for (int i = 0; i < set_len; i++)
        offer_record(pick_key(mix), $urandom, i == set_len - 1);
      if (set_len > rks_pkg::MAX_RECORDS)
        drops_forced++;
      stored += (set_len > rks_pkg::MAX_RECORDS) ? rks_pkg::MAX_RECORDS : set_len;
    end

    // Release the input and let the checker take in the last transaction,
    // wait for every sorted result, then keep the clock running for
    // anything unexpected.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4 * rks_pkg::MAX_RECORDS) @(posedge clk);

    $display("covered %0d records in %0d sets (%0d with a full store), %0d results checked",
             items_sent, sets_sent, drops_forced, results_checked);
    $display("keys: full range, clustered ties and extremes; random sender gaps and receiver stalls");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legitimate run.
  initial begin
    #8000000;
    $display("timeout waiting for transactions");
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rks_pkg.sv
rtl/rks_cell.sv
rtl/rank_sort_by_key.sv
tb/rank_sort_checker.sv
tb/tb_top.sv
